FILE: design/mpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle package
// Shared codes, default widths and arithmetic constants of the circle walker.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int X_BITS_DEF      = 8;
  localparam int Y_BITS_DEF      = 9;
  localparam int RADIUS_BITS_DEF = 8;
  localparam int COLOR_BITS      = 16;

  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  typedef logic [2:0] octant_t;

  localparam octant_t OCT_FIRST = 3'd0;
  localparam octant_t OCT_LAST  = 3'd7;

  localparam int DEC_INIT  = 3;
  localparam int DEC_DIAG  = 10;
  localparam int DEC_HORIZ = 6;

endpackage
`default_nettype wire

FILE: design/mpc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circle command channel
// Valid/ready channel carrying start and tick items into the circle walker.
// ----------------------------------------------------------------------------
interface mpc_in_if #(
  parameter int X_BITS      = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS      = mpc_pkg::Y_BITS_DEF,
  parameter int RADIUS_BITS = mpc_pkg::RADIUS_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [X_BITS-1:0]               center_x;
  logic [Y_BITS-1:0]               center_y;
  logic [RADIUS_BITS-1:0]          radius;
  logic [mpc_pkg::COLOR_BITS-1:0]  pixel_color;
  logic                            filled;

  modport source (
    output valid, action, center_x, center_y, radius, pixel_color, filled,
    input  ready
  );
  modport sink (
    input  valid, action, center_x, center_y, radius, pixel_color, filled,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/mpc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circle pixel channel
// Valid/ready channel carrying generated pixels out of the circle walker.
// ----------------------------------------------------------------------------
interface mpc_out_if #(
  parameter int X_BITS = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS = mpc_pkg::Y_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [X_BITS-1:0]              point_x;
  logic [Y_BITS-1:0]              point_y;
  logic [mpc_pkg::COLOR_BITS-1:0] point_color;
  logic                           last_point;

  modport source (
    output valid, point_x, point_y, point_color, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_color, last_point,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/mpc_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Octant point mapper
// Maps the step offsets onto one of the eight symmetric pixels of a circle.
// ----------------------------------------------------------------------------
module mpc_point #(
  parameter int X_BITS      = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS      = mpc_pkg::Y_BITS_DEF,
  parameter int RADIUS_BITS = mpc_pkg::RADIUS_BITS_DEF
) (
  input  wire logic [X_BITS-1:0]      cx_i,
  input  wire logic [Y_BITS-1:0]      cy_i,
  input  wire logic [RADIUS_BITS:0]   off_a_i,
  input  wire logic [RADIUS_BITS:0]   off_c_i,
  input  wire mpc_pkg::octant_t       octant_i,
  output logic      [X_BITS-1:0]      px_o,
  output logic      [Y_BITS-1:0]      py_o
);

  localparam int OFF_W = RADIUS_BITS + 1;
  localparam int XS_W  = (X_BITS > OFF_W) ? X_BITS : OFF_W;
  localparam int YS_W  = (Y_BITS > OFF_W) ? Y_BITS : OFF_W;

  logic [XS_W-1:0] cx_w, xa_p, xa_m, xc_p, xc_m;
  logic [YS_W-1:0] cy_w, ya_p, ya_m, yc_p, yc_m;
  logic [XS_W-1:0] px_w;
  logic [YS_W-1:0] py_w;

  assign cx_w = XS_W'(cx_i);
  assign cy_w = YS_W'(cy_i);
  assign xa_p = cx_w + XS_W'(off_a_i);
  assign xa_m = cx_w - XS_W'(off_a_i);
  assign xc_p = cx_w + XS_W'(off_c_i);
  assign xc_m = cx_w - XS_W'(off_c_i);
  assign ya_p = cy_w + YS_W'(off_a_i);
  assign ya_m = cy_w - YS_W'(off_a_i);
  assign yc_p = cy_w + YS_W'(off_c_i);
  assign yc_m = cy_w - YS_W'(off_c_i);

  always_comb begin
    unique case (octant_i)
      3'd0: begin px_w = xa_p; py_w = yc_m; end
      3'd1: begin px_w = xc_p; py_w = ya_m; end
      3'd2: begin px_w = xc_p; py_w = ya_p; end
      3'd3: begin px_w = xa_p; py_w = yc_p; end
      3'd4: begin px_w = xa_m; py_w = yc_p; end
      3'd5: begin px_w = xc_m; py_w = ya_p; end
      3'd6: begin px_w = xc_m; py_w = ya_m; end
      default: begin px_w = xa_m; py_w = yc_m; end
    endcase
  end

  assign px_o = px_w[X_BITS-1:0];
  assign py_o = py_w[Y_BITS-1:0];

endmodule
`default_nettype wire

FILE: design/midpoint_circle_point_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle point generator
// Walks a Bresenham midpoint circle and hands out one pixel per tick item.
// ----------------------------------------------------------------------------
// Usage:
// The command channel in_i carries start and tick items. A start item loads
// the centre, radius, colour and outline or filled mode and produces no pixel;
// a start while a circle is running replaces it. Each tick item accepted
// while a circle is running produces exactly one pixel on out_o; ticks with
// no circle running are taken and dropped. The final pixel of a circle has
// last_point set.
// The pixel for a tick is registered: it is valid on out_o in the cycle
// after the tick is accepted. One item is accepted every cycle while out_o
// is not stalled, as a single step of decision and octant logic lies
// between the state registers and the pixel register. When the receiver
// stalls, the pixel is held in the output register and in_i is not ready
// until it has been transferred.
// Reset leaves the block idle with no pixel pending.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_top #(
  parameter int X_BITS      = mpc_pkg::X_BITS_DEF,
  parameter int Y_BITS      = mpc_pkg::Y_BITS_DEF,
  parameter int RADIUS_BITS = mpc_pkg::RADIUS_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpc_in_if.sink    in_i,
  mpc_out_if.source out_o
);

  localparam int AB_W = RADIUS_BITS + 2;
  localparam int D_W  = RADIUS_BITS + 5;
  localparam int CW   = mpc_pkg::COLOR_BITS;

  logic                    busy_q, busy_d;
  logic [X_BITS-1:0]       cx_q, cx_d;
  logic [Y_BITS-1:0]       cy_q, cy_d;
  logic [CW-1:0]           color_q, color_d;
  logic                    fill_q, fill_d;
  logic signed [AB_W-1:0]  a_q, a_d, b_q, b_d, fc_q, fc_d;
  logic signed [AB_W-1:0]  a_nx, diff;
  mpc_pkg::octant_t        oct_q, oct_d;
  logic signed [D_W-1:0]   dec_q, dec_d;

  logic                    out_valid_q, out_valid_d;
  logic [X_BITS-1:0]       out_x_q;
  logic [Y_BITS-1:0]       out_y_q;
  logic [CW-1:0]           out_color_q;
  logic                    out_last_q, out_last_d;

  logic                    in_fire, emit;
  logic signed [AB_W-1:0]  c_sel;
  logic [X_BITS-1:0]       px;
  logic [Y_BITS-1:0]       py;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign c_sel      = fill_q ? fc_q : b_q;

  mpc_point #(
    .X_BITS      (X_BITS),
    .Y_BITS      (Y_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_point (
    .cx_i     (cx_q),
    .cy_i     (cy_q),
    .off_a_i  (a_q[RADIUS_BITS:0]),
    .off_c_i  (c_sel[RADIUS_BITS:0]),
    .octant_i (oct_q),
    .px_o     (px),
    .py_o     (py)
  );

  always_comb begin
    busy_d      = busy_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    color_d     = color_q;
    fill_d      = fill_q;
    a_d         = a_q;
    b_d         = b_q;
    fc_d        = fc_q;
    oct_d       = oct_q;
    dec_d       = dec_q;
    emit        = 1'b0;
    out_last_d  = 1'b0;
    a_nx        = a_q + AB_W'(1);
    diff        = a_nx - b_q;
    if (in_fire) begin
      if (in_i.action == mpc_pkg::ACTION_START) begin
        busy_d  = 1'b1;
        cx_d    = in_i.center_x;
        cy_d    = in_i.center_y;
        color_d = in_i.pixel_color;
        fill_d  = in_i.filled;
        a_d     = '0;
        b_d     = signed'(AB_W'(in_i.radius));
        fc_d    = '0;
        oct_d   = mpc_pkg::OCT_FIRST;
        dec_d   = signed'(D_W'(mpc_pkg::DEC_INIT)) - signed'(D_W'({in_i.radius, 1'b0}));
      end else if (busy_q) begin
        emit = 1'b1;
        if (oct_q != mpc_pkg::OCT_LAST) begin
          oct_d = oct_q + 3'd1;
        end else begin
          oct_d = mpc_pkg::OCT_FIRST;
          if (fill_q && (fc_q < b_q)) begin
            fc_d = fc_q + AB_W'(1);
          end else begin
            a_d  = a_nx;
            fc_d = a_nx;
            if (dec_q < 0) begin
              dec_d = dec_q + (D_W'(a_nx) <<< 2) + D_W'(mpc_pkg::DEC_HORIZ);
            end else begin
              dec_d = dec_q + (D_W'(diff) <<< 2) + D_W'(mpc_pkg::DEC_DIAG);
              b_d   = b_q - AB_W'(1);
            end
            if (a_nx > b_d) begin
              busy_d     = 1'b0;
              out_last_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      color_q     <= '0;
      fill_q      <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      fc_q        <= '0;
      oct_q       <= mpc_pkg::OCT_FIRST;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      color_q     <= color_d;
      fill_q      <= fill_d;
      a_q         <= a_d;
      b_q         <= b_d;
      fc_q        <= fc_d;
      oct_q       <= oct_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_color_q <= color_q;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_x     = out_x_q;
  assign out_o.point_y     = out_y_q;
  assign out_o.point_color = out_color_q;
  assign out_o.last_point  = out_last_q;

`ifndef SYNTH
  a_last_ends_circle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> !busy_q)
    else $error("Final pixel pending while a circle is still running.");

  a_octant_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oct_q != mpc_pkg::OCT_FIRST) |-> busy_q)
    else $error("Octant advanced with no circle running.");

  a_step_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (a_q <= b_q) && (a_q >= 0))
    else $error("Running circle has step offsets out of order.");

  a_fill_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && fill_q) |-> (fc_q >= a_q) && (fc_q <= b_q))
    else $error("Fill offset outside the current span.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(out_x_q) && $stable(out_y_q))
    else $error("Pending pixel changed while the receiver stalled.");
`endif

endmodule
`default_nettype wire
